// ===== src/multicast_group_forward_table_defines.svh =====
// assertion macros for the multicast group forwarding table checker
// no dependencies; included by the checker file only
`ifndef MULTICAST_GROUP_FORWARD_TABLE_DEFINES_SVH
`define MULTICAST_GROUP_FORWARD_TABLE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define MGFT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define MGFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mgft_pkg.sv =====
// shared types and constants for the multicast group forwarding table
// no dependencies
package mgft_pkg;

  localparam logic [2:0] REQ_ADD_IF  = 3'd0;
  localparam logic [2:0] REQ_ADD_GRP = 3'd1;
  localparam logic [2:0] REQ_DEL_GRP = 3'd2;
  localparam logic [2:0] REQ_FWD     = 3'd3;
  localparam logic [2:0] REQ_QUERY   = 3'd4;
  localparam logic [2:0] REQ_GET_NBR = 3'd5;

  localparam int unsigned RESULT_CAP = 8;
  localparam int unsigned RES_CNT_W  = 3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] iface_hi;
    logic [63:0] iface_lo;
    logic [63:0] group_hi;
    logic [63:0] group_lo;
    logic [63:0] source_hi;
    logic [63:0] source_lo;
    logic [63:0] neighbor_hi;
    logic [63:0] neighbor_lo;
  } mgft_req_t;

  typedef struct packed {
    logic        status;
    logic [63:0] dest_hi;
    logic [63:0] dest_lo;
    logic        last;
  } mgft_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } mgft_state_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic clr;
    logic rd_en;
    logic commit;
    logic if_wr;
    logic chain_load;
    logic chain_fwd;
    logic chain_shift;
  } mgft_ctl_t;

  // per-cell scan outcome
  typedef struct packed {
    logic iface_match;
    logic can_add;
    logic can_del;
    logic gs_hit;
  } mgft_flags_t;

  // one stage of the result chain
  typedef struct packed {
    logic        hit;
    logic [63:0] nbr_hi;
    logic [63:0] nbr_lo;
  } mgft_link_t;

endpackage

// ===== src/mgft_cell.sv =====
// one interface cell: address, neighbor, group entry memory and a chain stage
// depends on mgft_pkg
module mgft_cell import mgft_pkg::*; #(
  parameter int MAX_IFACES = 8,
  parameter int MAX_GROUPS = 16,
  parameter int INDEX      = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mgft_ctl_t                             ctl,
  input  logic [((MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1)-1:0] rd_slot,
  input  mgft_req_t                             req,
  input  logic [$clog2(MAX_IFACES+1)-1:0]       count,
  output mgft_flags_t                           flags,
  input  mgft_link_t                            link_in,
  output mgft_link_t                            link_out
);

  localparam int SW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int NCW = $clog2(MAX_IFACES + 1);

  logic [63:0]  addr_hi_r, addr_lo_r, nbr_hi_r, nbr_lo_r;
  logic [255:0] mem [MAX_GROUPS];
  logic [255:0] rd_data_r;
  logic [SW-1:0] rd_slot_r;
  logic         rd_vld_r;
  logic         cmp_en_r;
  logic [MAX_GROUPS-1:0] valid_r;
  logic         grp_hit_r, gs_hit_r, free_r;
  logic [SW-1:0] grp_slot_r, free_slot_r;
  mgft_link_t   link_r;

  logic active, iface_match, sel, gm, sm, wr_grp, del_grp;

  assign active      = NCW'(INDEX) < count;
  assign iface_match = active && (addr_hi_r == req.iface_hi) && (addr_lo_r == req.iface_lo);
  assign sel         = NCW'(INDEX) == count;
  assign gm = rd_vld_r && (rd_data_r[255:192] == req.group_hi)
              && (rd_data_r[191:128] == req.group_lo);
  assign sm = gm && (rd_data_r[127:64] == req.source_hi) && (rd_data_r[63:0] == req.source_lo);

  assign flags.iface_match = iface_match;
  assign flags.can_add     = iface_match && !grp_hit_r && free_r;
  assign flags.can_del     = iface_match && grp_hit_r;
  assign flags.gs_hit      = active && gs_hit_r;

  assign wr_grp  = ctl.commit && (req.req_type == REQ_ADD_GRP) && flags.can_add;
  assign del_grp = ctl.commit && (req.req_type == REQ_DEL_GRP) && flags.can_del;

  assign link_out = link_r;

  // entry memory and interface payload
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_slot];
      rd_slot_r <= rd_slot;
    end
    if (wr_grp) begin
      mem[free_slot_r] <= {req.group_hi, req.group_lo, req.source_hi, req.source_lo};
    end
    if (ctl.if_wr && sel) begin
      addr_hi_r <= req.iface_hi;
      addr_lo_r <= req.iface_lo;
      nbr_hi_r  <= req.neighbor_hi;
      nbr_lo_r  <= req.neighbor_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cmp_en_r    <= 1'b0;
      rd_vld_r    <= 1'b0;
      grp_hit_r   <= 1'b0;
      gs_hit_r    <= 1'b0;
      free_r      <= 1'b0;
      grp_slot_r  <= '0;
      free_slot_r <= '0;
      link_r      <= '0;
    end else begin
      cmp_en_r <= ctl.rd_en;
      rd_vld_r <= valid_r[rd_slot];
      if (ctl.if_wr && sel) begin
        valid_r <= '0;
      end else if (wr_grp) begin
        valid_r[free_slot_r] <= 1'b1;
      end else if (del_grp) begin
        valid_r[grp_slot_r] <= 1'b0;
      end
      if (ctl.clr) begin
        grp_hit_r <= 1'b0;
        gs_hit_r  <= 1'b0;
        free_r    <= 1'b0;
      end else if (cmp_en_r) begin
        if (gm) begin
          grp_hit_r  <= 1'b1;
          grp_slot_r <= rd_slot_r;
        end
        if (sm) begin
          gs_hit_r <= 1'b1;
        end
        // lowest free slot wins
        if (!rd_vld_r && !free_r) begin
          free_r      <= 1'b1;
          free_slot_r <= rd_slot_r;
        end
      end
      if (ctl.chain_load) begin
        link_r.hit    <= ctl.chain_fwd ? (active && grp_hit_r) : iface_match;
        link_r.nbr_hi <= nbr_hi_r;
        link_r.nbr_lo <= nbr_lo_r;
      end else if (ctl.chain_shift) begin
        link_r <= link_in;
      end
    end
  end

endmodule

// ===== src/multicast_group_forward_table.sv =====
// multicast group forwarding table top level: sequencer and row of interface cells
// depends on mgft_pkg and mgft_cell
//
//  channel  ports                         transfer when
//  request  start, busy, in_req           start high and busy low
//  result   out_valid, out_res            out_valid high, one cycle, no stall
//
// busy holds after a request transfer through the scan state (all cells read their entry
// memories in parallel through a registered port) and the decision state; a single result
// shows in the first cycle busy is low again.
// forward and get-neighbor then shift the cell chain one interface a cycle, busy still high;
// results leave the chain head as hits arrive.
// synchronous active-low reset empties the table; the receiver cannot stall.
module multicast_group_forward_table import mgft_pkg::*; #(
  parameter int MAX_IFACES = 8,
  parameter int MAX_GROUPS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  mgft_req_t in_req,
  output logic      out_valid,
  output mgft_res_t out_res
);

  localparam int SW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int CW  = $clog2(MAX_GROUPS + 1);
  localparam int NCW = $clog2(MAX_IFACES + 1);

  mgft_state_t state_r, state_nxt;
  mgft_req_t   req_r;
  logic [CW-1:0]        slot_r, slot_nxt;
  logic [NCW-1:0]       count_r, count_nxt;
  logic [RES_CNT_W-1:0] n_r, n_nxt;
  logic      out_valid_r, out_valid_nxt;
  mgft_res_t out_res_r, out_res_nxt;
  mgft_ctl_t ctl;

  mgft_flags_t flags [MAX_IFACES];
  mgft_link_t  link  [MAX_IFACES];
  mgft_link_t  link_tail [MAX_IFACES];

  logic any_match, any_add, any_del, any_gs, rest_any, head_last;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_IFACES; gi++) begin : g_cell
      if (gi == MAX_IFACES - 1) begin : g_end
        assign link_tail[gi] = '0;
      end else begin : g_mid
        assign link_tail[gi] = link[gi+1];
      end
      mgft_cell #(
        .MAX_IFACES(MAX_IFACES),
        .MAX_GROUPS(MAX_GROUPS),
        .INDEX(gi)
      ) u_cell (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(ctl),
        .rd_slot(slot_r[SW-1:0]),
        .req(req_r),
        .count(count_r),
        .flags(flags[gi]),
        .link_in(link_tail[gi]),
        .link_out(link[gi])
      );
    end
  endgenerate

  always_comb begin
    any_match = 1'b0;
    any_add   = 1'b0;
    any_del   = 1'b0;
    any_gs    = 1'b0;
    rest_any  = 1'b0;
    for (int i = 0; i < MAX_IFACES; i++) begin
      any_match = any_match | flags[i].iface_match;
      any_add   = any_add | flags[i].can_add;
      any_del   = any_del | flags[i].can_del;
      any_gs    = any_gs | flags[i].gs_hit;
      if (i > 0) begin
        rest_any = rest_any | link[i].hit;
      end
    end
    head_last = !rest_any || (n_r == RES_CNT_W'(RESULT_CAP - 1));
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (slot_r == CW'(MAX_GROUPS)) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (req_r.req_type == REQ_FWD || req_r.req_type == REQ_GET_NBR) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!link[0].hit && !rest_any) begin
          state_nxt = ST_IDLE;
        end else if (link[0].hit && head_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    ctl           = '0;
    slot_nxt      = slot_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '0;
    case (state_r)
      ST_IDLE: begin
        ctl.clr  = start;
        slot_nxt = '0;
      end
      ST_SCAN: begin
        ctl.rd_en = slot_r != CW'(MAX_GROUPS);
        if (slot_r != CW'(MAX_GROUPS)) slot_nxt = slot_r + CW'(1);
      end
      ST_DECIDE: begin
        ctl.commit     = 1'b1;
        ctl.chain_load = 1'b1;
        ctl.chain_fwd  = req_r.req_type == REQ_FWD;
        n_nxt          = '0;
        out_res_nxt.last   = 1'b1;
        out_res_nxt.status = STATUS_FAIL;
        case (req_r.req_type)
          REQ_ADD_IF: begin
            out_valid_nxt = 1'b1;
            if (!any_match && (count_r < NCW'(MAX_IFACES))) begin
              ctl.if_wr          = 1'b1;
              count_nxt          = count_r + NCW'(1);
              out_res_nxt.status = STATUS_OK;
            end
          end
          REQ_ADD_GRP: begin
            out_valid_nxt = 1'b1;
            if (any_add) out_res_nxt.status = STATUS_OK;
          end
          REQ_DEL_GRP: begin
            out_valid_nxt = 1'b1;
            if (any_del) out_res_nxt.status = STATUS_OK;
          end
          REQ_QUERY: begin
            out_valid_nxt = 1'b1;
            if (any_gs) out_res_nxt.status = STATUS_OK;
          end
          REQ_FWD, REQ_GET_NBR: begin
            out_valid_nxt = 1'b0;
          end
          default: begin
            out_valid_nxt = 1'b1;
          end
        endcase
      end
      ST_EMIT: begin
        ctl.chain_shift = 1'b1;
        if (!link[0].hit && !rest_any) begin
          // nothing matched at all
          out_valid_nxt      = 1'b1;
          out_res_nxt.status = STATUS_FAIL;
          out_res_nxt.last   = 1'b1;
        end else if (link[0].hit) begin
          out_valid_nxt       = 1'b1;
          out_res_nxt.status  = STATUS_OK;
          out_res_nxt.dest_hi = link[0].nbr_hi;
          out_res_nxt.dest_lo = link[0].nbr_lo;
          out_res_nxt.last    = head_last;
          n_nxt               = n_r + RES_CNT_W'(1);
        end
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_req;
    end
    out_res_r <= out_res_nxt;
    slot_r    <= slot_nxt;
    n_r       <= n_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/mgft_chk.sv =====
// port-level checker for the multicast group forwarding table, bound to the top level
// depends on mgft_pkg and multicast_group_forward_table_defines.svh
`include "multicast_group_forward_table_defines.svh"

module mgft_chk import mgft_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input mgft_req_t in_req,
  input logic      out_valid,
  input mgft_res_t out_res
);

  `MGFT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "no busy after request transfer")
  `MGFT_ASSERT_NOW(a_more_follow, out_valid && !out_res.last, busy, "idle before last result")
  `MGFT_ASSERT_NOW(a_fail_last, out_valid && out_res.status, out_res.last, "miss not final")
  `MGFT_ASSERT_NOW(a_fail_dest, out_valid && out_res.status,
    out_res.dest_hi == 64'd0 && out_res.dest_lo == 64'd0, "miss with nonzero dest")

endmodule

bind multicast_group_forward_table mgft_chk u_chk (.*);

// ===== sim/multicast_group_forward_table_test.sv =====
// testbench for the multicast group forwarding table: random and directed requests
// depends on mgft_pkg and the multicast_group_forward_table rtl
`timescale 1ns / 1ps

module multicast_group_forward_table_test;
  import mgft_pkg::*;

  localparam int N_IF = 8;
  localparam int N_GRP = 16;

  // request codes the block does not define
  localparam logic [2:0] REQ_UNDEF_LO = 3'd6;
  localparam logic [2:0] REQ_UNDEF_HI = 3'd7;

  class table_scoreboard;
    logic [63:0] if_hi [N_IF];
    logic [63:0] if_lo [N_IF];
    logic [63:0] nb_hi [N_IF];
    logic [63:0] nb_lo [N_IF];
    int unsigned if_cnt;
    bit          vld [N_IF*N_GRP];
    logic [63:0] g_hi [N_IF*N_GRP];
    logic [63:0] g_lo [N_IF*N_GRP];
    logic [63:0] s_hi [N_IF*N_GRP];
    logic [63:0] s_lo [N_IF*N_GRP];
    mgft_res_t   pending [$];
    int          errors;

    function new();
      if_cnt = 0;
      errors = 0;
      foreach (vld[k]) vld[k] = 0;
    endfunction

    function int find_if(logic [63:0] h, logic [63:0] l);
      for (int i = 0; i < if_cnt; i++)
        if (if_hi[i] == h && if_lo[i] == l) return i;
      return -1;
    endfunction

    function int find_grp(int ifc, logic [63:0] h, logic [63:0] l);
      int e;
      for (int s = 0; s < N_GRP; s++) begin
        e = ifc * N_GRP + s;
        if (vld[e] && g_hi[e] == h && g_lo[e] == l) return e;
      end
      return -1;
    endfunction

    function void push(logic st, logic [63:0] h, logic [63:0] l, logic lst);
      mgft_res_t r;
      r.status = st;
      r.dest_hi = h;
      r.dest_lo = l;
      r.last = lst;
      pending = {pending, r};
    endfunction

    // note one accepted request and queue what it should produce
    function void note_request(mgft_req_t q);
      int ifc, e, n;
      bit hit;
      case (q.req_type)
        REQ_ADD_IF: begin
          if (find_if(q.iface_hi, q.iface_lo) >= 0 || if_cnt >= N_IF) begin
            push(STATUS_FAIL, 0, 0, 1);
          end else begin
            for (int s = 0; s < N_GRP; s++) vld[if_cnt*N_GRP+s] = 0;
            if_hi[if_cnt] = q.iface_hi;
            if_lo[if_cnt] = q.iface_lo;
            nb_hi[if_cnt] = q.neighbor_hi;
            nb_lo[if_cnt] = q.neighbor_lo;
            if_cnt++;
            push(STATUS_OK, 0, 0, 1);
          end
        end
        REQ_ADD_GRP: begin
          ifc = find_if(q.iface_hi, q.iface_lo);
          hit = 0;
          if (ifc >= 0 && find_grp(ifc, q.group_hi, q.group_lo) < 0) begin
            for (int s = 0; s < N_GRP && !hit; s++) begin
              e = ifc * N_GRP + s;
              if (!vld[e]) begin
                vld[e] = 1;
                g_hi[e] = q.group_hi;
                g_lo[e] = q.group_lo;
                s_hi[e] = q.source_hi;
                s_lo[e] = q.source_lo;
                hit = 1;
              end
            end
          end
          push(hit ? STATUS_OK : STATUS_FAIL, 0, 0, 1);
        end
        REQ_DEL_GRP: begin
          ifc = find_if(q.iface_hi, q.iface_lo);
          e = (ifc < 0) ? -1 : find_grp(ifc, q.group_hi, q.group_lo);
          if (e >= 0) vld[e] = 0;
          push(e >= 0 ? STATUS_OK : STATUS_FAIL, 0, 0, 1);
        end
        REQ_FWD: begin
          n = 0;
          for (int i = 0; i < if_cnt && n < RESULT_CAP; i++)
            if (find_grp(i, q.group_hi, q.group_lo) >= 0) begin
              push(STATUS_OK, nb_hi[i], nb_lo[i], 0);
              n++;
            end
          if (n == 0) push(STATUS_FAIL, 0, 0, 1);
          else pending[$].last = 1;
        end
        REQ_QUERY: begin
          hit = 0;
          for (int x = 0; x < if_cnt * N_GRP; x++)
            if (vld[x] && g_hi[x] == q.group_hi && g_lo[x] == q.group_lo &&
                s_hi[x] == q.source_hi && s_lo[x] == q.source_lo) hit = 1;
          push(hit ? STATUS_OK : STATUS_FAIL, 0, 0, 1);
        end
        REQ_GET_NBR: begin
          ifc = find_if(q.iface_hi, q.iface_lo);
          if (ifc < 0) push(STATUS_FAIL, 0, 0, 1);
          else push(STATUS_OK, nb_hi[ifc], nb_lo[ifc], 1);
        end
        default: push(STATUS_FAIL, 0, 0, 1);
      endcase
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_result(mgft_res_t r);
      mgft_res_t w;
      if (pending.size() == 0) begin
        report("unexpected result", r.dest_lo, 0);
        return;
      end
      w = pending.pop_front();
      if (r.status !== w.status) report("status", r.status, w.status);
      if (r.dest_hi !== w.dest_hi) report("dest_hi", r.dest_hi, w.dest_hi);
      if (r.dest_lo !== w.dest_lo) report("dest_lo", r.dest_lo, w.dest_lo);
      if (r.last !== w.last) report("last", r.last, w.last);
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  mgft_req_t in_req;
  logic      out_valid;
  mgft_res_t out_res;

  table_scoreboard sb;
  int burst_left;

  // small address pools so that requests hit stored state often
  logic [63:0] pool_hi [6];
  logic [63:0] pool_lo [6];

  multicast_group_forward_table #(.MAX_IFACES(N_IF), .MAX_GROUPS(N_GRP)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("multicast_group_forward_table test failed");
    $finish;
  end

  always @(posedge clk)
    if (rst_n && out_valid) sb.check_result(out_res);

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_hi();
    int k;
    k = $urandom_range(0, 9);
    return (k < 6) ? pool_hi[k] : rnd64();
  endfunction

  function automatic logic [63:0] pick_lo();
    int k;
    k = $urandom_range(0, 9);
    return (k < 6) ? pool_lo[k] : rnd64();
  endfunction

  // one request transfer; start stays high inside a burst and drops only for a gap
  task automatic send(mgft_req_t q);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 30);
      if (gap > 0) begin
        start <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1;
    in_req <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(q);
  endtask

  function automatic mgft_req_t make_req(logic [2:0] op);
    mgft_req_t q;
    int k;
    q.req_type = op;
    k = $urandom_range(0, 5);
    q.iface_hi = ($urandom_range(0, 7) != 0) ? pool_hi[k] : rnd64();
    q.iface_lo = ($urandom_range(0, 7) != 0) ? pool_lo[k] : rnd64();
    q.group_hi = pick_hi();
    q.group_lo = pick_lo();
    q.source_hi = pick_hi();
    q.source_lo = pick_lo();
    q.neighbor_hi = rnd64();
    q.neighbor_lo = rnd64();
    return q;
  endfunction

  initial begin
    mgft_req_t q;
    int t;
    sb = new();
    burst_left = 0;
    rst_n = 0;
    start = 0;
    in_req = '0;
    pool_hi[0] = '0; pool_lo[0] = '0;
    pool_hi[1] = '1; pool_lo[1] = '1;
    for (int i = 2; i < 6; i++) begin
      pool_hi[i] = rnd64();
      pool_lo[i] = rnd64();
    end
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty table, extremes, duplicates, a full group table, unknown codes
    send(make_req(REQ_FWD));
    send(make_req(REQ_GET_NBR));
    q = '0; q.req_type = REQ_ADD_IF; send(q);
    send(q);
    q = '1; q.req_type = REQ_ADD_IF; send(q);
    q.req_type = REQ_GET_NBR; send(q);
    for (int g = 0; g < N_GRP + 1; g++) begin
      q = '1; q.req_type = REQ_ADD_GRP; q.group_lo = 64'(g); send(q);
    end
    q = '1; q.req_type = REQ_ADD_GRP; q.group_lo = 64'd3; send(q);
    q = '1; q.req_type = REQ_QUERY; q.group_lo = 64'd3; send(q);
    q = '1; q.req_type = REQ_DEL_GRP; q.group_lo = 64'd3; send(q);
    send(q);
    q = '1; q.req_type = REQ_FWD; q.group_lo = 64'd0; send(q);
    q = '1; q.req_type = REQ_UNDEF_LO; send(q);
    q = '0; q.req_type = REQ_UNDEF_HI; send(q);

    // random: mostly well-formed operations on the pooled addresses
    for (int n = 0; n < 450; n++) begin
      t = $urandom_range(0, 99);
      if (t < 12) q = make_req(REQ_ADD_IF);
      else if (t < 40) q = make_req(REQ_ADD_GRP);
      else if (t < 52) q = make_req(REQ_DEL_GRP);
      else if (t < 72) q = make_req(REQ_FWD);
      else if (t < 84) q = make_req(REQ_QUERY);
      else if (t < 96) q = make_req(REQ_GET_NBR);
      else begin
        q = make_req(REQ_UNDEF_LO);
        if ($urandom_range(0, 1) != 0) q.req_type = REQ_UNDEF_HI;
      end
      send(q);
    end
    start <= 0;

    t = 0;
    while (sb.pending.size() != 0 && t < 10000) begin
      @(posedge clk);
      t++;
    end
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("multicast_group_forward_table test passed");
    else
      $display("multicast_group_forward_table test failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/mgft_pkg.sv
src/mgft_cell.sv
src/multicast_group_forward_table.sv
src/mgft_chk.sv
sim/multicast_group_forward_table_test.sv
